// ===== src/risc_integer_execute_unit_macros.svh =====
// Assertion helpers for the execute unit.
`ifndef RISC_INTEGER_EXECUTE_UNIT_MACROS_SVH
`define RISC_INTEGER_EXECUTE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define RIE_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define RIE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/rie_pkg.sv =====
package rie_pkg;

  localparam int DATA_DEPTH_DEFAULT = 1024;

  localparam int XLEN    = 32;
  localparam int REG_W   = 5;
  localparam int WADDR_W = 10;
  localparam int ADDR_W  = 30;

  localparam logic [1:0] MODE_EXEC      = 2'd0;
  localparam logic [1:0] MODE_LOAD_REG  = 2'd1;
  localparam logic [1:0] MODE_LOAD_WORD = 2'd2;

  localparam logic [5:0] OP_RTYPE = 6'b000000;
  localparam logic [5:0] OP_ADDI  = 6'b001000;
  localparam logic [5:0] OP_ADDIU = 6'b001001;
  localparam logic [5:0] OP_SLTI  = 6'b001010;
  localparam logic [5:0] OP_ANDI  = 6'b001100;
  localparam logic [5:0] OP_ORI   = 6'b001101;
  localparam logic [5:0] OP_XORI  = 6'b001110;
  localparam logic [5:0] OP_LW    = 6'b100011;

  localparam logic [5:0] FN_SLL  = 6'd0;
  localparam logic [5:0] FN_SRL  = 6'd2;
  localparam logic [5:0] FN_SRA  = 6'd3;
  localparam logic [5:0] FN_ADD  = 6'd32;
  localparam logic [5:0] FN_ADDU = 6'd33;
  localparam logic [5:0] FN_SUB  = 6'd34;
  localparam logic [5:0] FN_SUBU = 6'd35;
  localparam logic [5:0] FN_AND  = 6'd36;
  localparam logic [5:0] FN_OR   = 6'd37;
  localparam logic [5:0] FN_XOR  = 6'd38;
  localparam logic [5:0] FN_NOR  = 6'd39;
  localparam logic [5:0] FN_SLT  = 6'd42;

  typedef struct packed {
    logic [XLEN-1:0]   value;
    logic [REG_W-1:0]  dest;
    logic              wr;
    logic              ovf;
    logic              zero;
    logic              unsup;
    logic              lw;
    logic              st;
    logic [ADDR_W-1:0] addr;
  } exec_t;

endpackage

// ===== src/rie_req_if.sv =====
interface rie_req_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  mode;
  logic [rie_pkg::XLEN-1:0]    instruction;
  logic [rie_pkg::REG_W-1:0]   reg_index;
  logic [rie_pkg::WADDR_W-1:0] word_address;
  logic [rie_pkg::XLEN-1:0]    load_value;

  modport source (
    output valid, mode, instruction, reg_index, word_address, load_value,
    input  ready
  );
  modport sink (
    input  valid, mode, instruction, reg_index, word_address, load_value,
    output ready
  );
endinterface

// ===== src/rie_rsp_if.sv =====
interface rie_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [rie_pkg::XLEN-1:0]  result_value;
  logic [rie_pkg::REG_W-1:0] dest_reg;
  logic                      reg_written;
  logic                      overflow_flag;
  logic                      zero_flag;
  logic                      unsupported;

  modport source (
    output valid, result_value, dest_reg, reg_written, overflow_flag, zero_flag,
           unsupported,
    input  ready
  );
  modport sink (
    input  valid, result_value, dest_reg, reg_written, overflow_flag, zero_flag,
           unsupported,
    output ready
  );
endinterface

// ===== src/risc_integer_execute_unit.sv =====
// Pipeline: request register b, then stages c, d, e and f, then the output register.
// Throughput: one request per cycle unless the output is held; an instruction that
// reads the target of an LW still in the address or data store stages waits until that LW leaves them.
// Reset: register file reads as zero at once; the data store is cleared by a
// pass over all DATA_DEPTH words after reset, during which no request is taken.
`include "risc_integer_execute_unit_macros.svh"

module risc_integer_execute_unit #(
  parameter int DATA_DEPTH = rie_pkg::DATA_DEPTH_DEFAULT
) (
  input logic      clk,
  input logic      rst,
  rie_req_if.sink  req,
  rie_rsp_if.source rsp
);

  localparam int N  = rie_pkg::ADDR_W;
  localparam int AW = $clog2(DATA_DEPTH);
  localparam int MW = N + 1;
  localparam int PW = N + MW;
  localparam int QW = PW - N - AW;
  localparam int DW = AW + 1;
  localparam logic [63:0] MULT_FULL =
      ((64'd1 << (N + AW)) + 64'(DATA_DEPTH) - 64'd1) / 64'(DATA_DEPTH);
  localparam logic [MW-1:0] MULT = MULT_FULL[MW-1:0];
  localparam logic [DW-1:0] DEPTH_C = DW'(DATA_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(DATA_DEPTH - 1);

  logic                        b_valid;
  logic [1:0]                  b_mode;
  logic [rie_pkg::XLEN-1:0]    b_instruction;
  logic [rie_pkg::REG_W-1:0]   b_reg_index;
  logic [rie_pkg::WADDR_W-1:0] b_word_address;
  logic [rie_pkg::XLEN-1:0]    b_load_value;

  logic           c_valid, d_valid, e_valid, f_valid, o_valid;
  rie_pkg::exec_t b_x, c_x, d_x, e_x, f_x;
  logic [PW-1:0]  d_prod;
  logic [N-1:0]   e_qd;

  logic adv, b_move, hazard;

  logic [rie_pkg::XLEN-1:0]  rf_mem [32];
  logic [31:0]               rf_vld;
  logic [rie_pkg::REG_W-1:0] raddr [2];
  logic [rie_pkg::XLEN-1:0]  rf_q [2];
  logic                      rf_qv [2];
  logic                      rf_we;
  logic [rie_pkg::REG_W-1:0] rf_waddr;
  logic [rie_pkg::XLEN-1:0]  rf_wdata;

  logic                      lwr_valid;
  logic [rie_pkg::REG_W-1:0] lwr_idx;
  logic [rie_pkg::XLEN-1:0]  lwr_value;

  logic [rie_pkg::REG_W-1:0] src [2];
  logic [rie_pkg::XLEN-1:0]  opnd [2];
  logic                      haz [2];

  logic [rie_pkg::XLEN-1:0] dm_mem [DATA_DEPTH];
  logic [rie_pkg::XLEN-1:0] dm_q;
  logic [AW-1:0]            dm_idx;
  logic [N-1:0]             dm_diff;
  logic [QW-1:0]            d_q;
  logic [QW+DW-1:0]         d_qd_full;
  logic                     dm_we;
  logic [AW-1:0]            dm_waddr;
  logic [rie_pkg::XLEN-1:0] dm_wdata;
  logic                     clearing;
  logic [AW-1:0]            clr_idx;

  logic [rie_pkg::XLEN-1:0] f_value;

  assign adv       = !o_valid || rsp.ready;
  assign b_move    = b_valid && adv && !hazard;
  assign req.ready = !clearing && (!b_valid || b_move);
  assign rsp.valid = o_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (req.ready) begin
      b_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready) begin
      b_mode         <= req.mode;
      b_instruction  <= req.instruction;
      b_reg_index    <= req.reg_index;
      b_word_address <= req.word_address;
      b_load_value   <= req.load_value;
    end
  end

  // register file: two read ports, read data registered
  assign raddr[0] = req.ready ? req.instruction[25:21] : b_instruction[25:21];
  assign raddr[1] = req.ready ? req.instruction[20:16] : b_instruction[20:16];

  assign f_value  = f_x.lw ? dm_q : f_x.value;
  assign rf_we    = adv && f_valid && f_x.wr;
  assign rf_waddr = f_x.dest;
  assign rf_wdata = f_value;

  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf_mem[rf_waddr] <= rf_wdata;
    end
    for (int i = 0; i < 2; i++) begin
      rf_q[i] <= rf_mem[raddr[i]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_vld    <= '0;
      lwr_valid <= 1'b0;
    end else begin
      if (rf_we) begin
        rf_vld[rf_waddr] <= 1'b1;
      end
      lwr_valid <= rf_we;
    end
  end

  always_ff @(posedge clk) begin
    lwr_idx   <= rf_waddr;
    lwr_value <= rf_wdata;
    for (int i = 0; i < 2; i++) begin
      rf_qv[i] <= rf_vld[raddr[i]];
    end
  end

  // forward in-flight writes, youngest last; stall on a pending load
  assign src[0] = b_instruction[25:21];
  assign src[1] = b_instruction[20:16];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      opnd[i] = rf_qv[i] ? rf_q[i] : '0;
      haz[i]  = 1'b0;
      if (lwr_valid && lwr_idx == src[i]) begin
        opnd[i] = lwr_value;
      end
      if (f_valid && f_x.wr && f_x.dest == src[i]) begin
        opnd[i] = f_value;
        haz[i]  = 1'b0;
      end
      if (e_valid && e_x.wr && e_x.dest == src[i]) begin
        opnd[i] = e_x.value;
        haz[i]  = e_x.lw;
      end
      if (d_valid && d_x.wr && d_x.dest == src[i]) begin
        opnd[i] = d_x.value;
        haz[i]  = d_x.lw;
      end
      if (c_valid && c_x.wr && c_x.dest == src[i]) begin
        opnd[i] = c_x.value;
        haz[i]  = c_x.lw;
      end
    end
  end

  assign hazard = b_valid && (b_mode == rie_pkg::MODE_EXEC) && (haz[0] || haz[1]);

  rie_alu u_alu (
    .mode         (b_mode),
    .instruction  (b_instruction),
    .reg_index    (b_reg_index),
    .word_address (b_word_address),
    .load_value   (b_load_value),
    .opa          (opnd[0]),
    .opb          (opnd[1]),
    .res          (b_x)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
      d_valid <= 1'b0;
      e_valid <= 1'b0;
      f_valid <= 1'b0;
      o_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= b_valid && !hazard;
      d_valid <= c_valid;
      e_valid <= d_valid;
      f_valid <= e_valid;
      o_valid <= f_valid;
    end
  end

  // word index modulo depth: reciprocal multiply, back-multiply, subtract
  assign d_q       = d_prod[PW-1:N+AW];
  assign d_qd_full = QW'(d_q) * DEPTH_C;
  assign dm_diff   = e_x.addr - e_qd;
  assign dm_idx    = dm_diff[AW-1:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      c_x    <= b_x;
      d_x    <= c_x;
      d_prod <= PW'(c_x.addr) * PW'(MULT);
      e_x    <= d_x;
      e_qd   <= d_qd_full[N-1:0];
      f_x    <= e_x;
    end
  end

  // data store
  assign dm_we    = clearing || (adv && e_valid && e_x.st);
  assign dm_waddr = clearing ? clr_idx : dm_idx;
  assign dm_wdata = clearing ? '0 : e_x.value;

  always_ff @(posedge clk) begin
    if (dm_we) begin
      dm_mem[dm_waddr] <= dm_wdata;
    end
    if (adv) begin
      dm_q <= dm_mem[dm_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + AW'(1);
      if (clr_idx == LAST_IDX) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp.result_value  <= f_value;
      rsp.dest_reg      <= f_x.dest;
      rsp.reg_written   <= f_x.wr;
      rsp.overflow_flag <= f_x.ovf;
      rsp.zero_flag     <= f_x.zero;
      rsp.unsupported   <= f_x.unsup;
    end
  end

  `RIE_ASSERT_IMPL(a_no_accept_clear, clk, rst, clearing, !req.ready, "request taken while clearing")
  `RIE_ASSERT_NEXT(a_accept_loads, clk, rst, req.valid && req.ready, b_valid, "accepted request lost")
  `RIE_ASSERT_IMPL(a_hazard_holds, clk, rst, hazard, !req.ready && !b_move, "load-use stall leaked")
  `RIE_ASSERT_IMPL(a_no_r0_write, clk, rst, rf_we, rf_waddr != 5'd0, "write to register zero")
  `RIE_ASSERT_IMPL(a_unsup_clean, clk, rst, rsp.valid && rsp.unsupported, rsp.result_value == 32'd0 && !rsp.reg_written && rsp.dest_reg == 5'd0, "unsupported result not clean")

endmodule

// ===== src/rie_alu.sv =====
module rie_alu (
  input  logic [1:0]                  mode,
  input  logic [rie_pkg::XLEN-1:0]    instruction,
  input  logic [rie_pkg::REG_W-1:0]   reg_index,
  input  logic [rie_pkg::WADDR_W-1:0] word_address,
  input  logic [rie_pkg::XLEN-1:0]    load_value,
  input  logic [rie_pkg::XLEN-1:0]    opa,
  input  logic [rie_pkg::XLEN-1:0]    opb,
  output rie_pkg::exec_t              res
);

  logic [5:0]                op;
  logic [5:0]                fn;
  logic [4:0]                sh;
  logic [rie_pkg::XLEN-1:0]  imm_z;
  logic [rie_pkg::XLEN-1:0]  imm_s;
  logic [rie_pkg::XLEN-1:0]  sum_rr;
  logic [rie_pkg::XLEN-1:0]  sum_ri;
  logic [rie_pkg::XLEN-1:0]  diff;
  logic [rie_pkg::XLEN-1:0]  alu;
  logic [rie_pkg::REG_W-1:0] dest;
  logic                      ovf;
  logic                      unsup;

  assign op     = instruction[31:26];
  assign fn     = instruction[5:0];
  assign sh     = instruction[10:6];
  assign imm_z  = {16'd0, instruction[15:0]};
  assign imm_s  = {{16{instruction[15]}}, instruction[15:0]};
  assign sum_rr = opa + opb;
  assign sum_ri = opa + imm_s;
  assign diff   = opa - opb;

  always_comb begin
    alu   = '0;
    ovf   = 1'b0;
    unsup = 1'b0;
    if (op == rie_pkg::OP_RTYPE) begin
      dest = instruction[15:11];
      case (fn)
        rie_pkg::FN_ADD: begin
          alu = sum_rr;
          ovf = ((opa[31] ^ sum_rr[31]) & (opb[31] ^ sum_rr[31]));
        end
        rie_pkg::FN_ADDU: alu = sum_rr;
        rie_pkg::FN_SUB: begin
          alu = diff;
          ovf = ((opa[31] ^ opb[31]) & (opa[31] ^ diff[31]));
        end
        rie_pkg::FN_SUBU: alu = diff;
        rie_pkg::FN_SLT:  alu = {31'd0, $signed(opa) < $signed(opb)};
        rie_pkg::FN_AND:  alu = opa & opb;
        rie_pkg::FN_OR:   alu = opa | opb;
        rie_pkg::FN_XOR:  alu = opa ^ opb;
        rie_pkg::FN_NOR:  alu = ~(opa | opb);
        rie_pkg::FN_SLL:  alu = opb << sh;
        rie_pkg::FN_SRL:  alu = opb >> sh;
        rie_pkg::FN_SRA:  alu = $signed(opb) >>> sh;
        default:          unsup = 1'b1;
      endcase
    end else begin
      dest = instruction[20:16];
      case (op)
        rie_pkg::OP_ADDI: begin
          alu = sum_ri;
          ovf = ((opa[31] ^ sum_ri[31]) & (imm_s[31] ^ sum_ri[31]));
        end
        rie_pkg::OP_ADDIU: alu = sum_ri;
        rie_pkg::OP_SLTI:  alu = {31'd0, $signed(opa) < $signed(imm_s)};
        rie_pkg::OP_ANDI:  alu = opa & imm_z;
        rie_pkg::OP_ORI:   alu = opa | imm_z;
        rie_pkg::OP_XORI:  alu = opa ^ imm_z;
        rie_pkg::OP_LW:    alu = sum_ri;
        default:           unsup = 1'b1;
      endcase
    end
  end

  always_comb begin
    res = '0;
    case (mode)
      rie_pkg::MODE_LOAD_REG: begin
        res.value = load_value;
        res.dest  = reg_index;
        res.wr    = (reg_index != '0);
      end
      rie_pkg::MODE_LOAD_WORD: begin
        res.value = load_value;
        res.st    = 1'b1;
        res.addr  = {{(rie_pkg::ADDR_W - rie_pkg::WADDR_W){1'b0}}, word_address};
      end
      rie_pkg::MODE_EXEC: begin
        if (unsup) begin
          res.unsup = 1'b1;
        end else begin
          res.value = alu;
          res.dest  = dest;
          res.wr    = (dest != '0);
          res.ovf   = ovf;
          res.zero  = (alu == '0);
          res.lw    = (op == rie_pkg::OP_LW);
          res.addr  = alu[31:2];
        end
      end
      default: res.unsup = 1'b1;
    endcase
  end

endmodule
